// ===== rtl/core/tss_pkg.sv =====
// Shared types, constants and microcode ROM for the tilemap scroll streamer.
// Depends on nothing; used by tss_sequencer and tilemap_scroll_streamer.
`timescale 1ns / 1ps

package tss_pkg;

   // Register map, word index on the APB port
   localparam logic [2:0] REG_MAP_LOADED   = 3'd0;
   localparam logic [2:0] REG_VIDEO_MODE   = 3'd1;
   localparam logic [2:0] REG_PLANE_SELECT = 3'd2;
   localparam logic [2:0] REG_WORLD_W      = 3'd3;
   localparam logic [2:0] REG_WORLD_H      = 3'd4;

   // Display modes with special handling
   localparam logic [2:0] VMODE_HIGH_A = 3'd1;
   localparam logic [2:0] VMODE_NARROW = 3'd4;

   localparam logic [8:0]  SCREEN_W_STD    = 9'd320;
   localparam logic [8:0]  SCREEN_W_NARROW = 9'd256;
   localparam logic [8:0]  SCREEN_H        = 9'd224;
   localparam logic [15:0] BASE_A_STD      = 16'h8000;
   localparam logic [15:0] BASE_B_STD      = 16'h9000;
   localparam logic [15:0] BASE_A_HIGH     = 16'hB000;

   typedef enum logic [1:0] {
      CMD_COLUMN = 2'd0,
      CMD_ROW    = 2'd1,
      CMD_REFILL = 2'd2,
      CMD_FINAL  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE, S_CLAMP, S_DELTA, S_DECIDE, S_COL, S_ROW, S_FINAL, S_REFILL
   } step_type;

   typedef enum logic [2:0] {
      C_NONE, C_NO_REQ, C_IGNORE, C_BIG, C_X_DONE, C_Y_DONE
   } cond_type;

   // One control word: jump to 'jump' when cond holds, else act and go to 'next'
   typedef struct packed {
      cond_type cond;
      step_type jump;
      step_type next;
      logic     ld_in;
      logic     ld_clamp;
      logic     ld_delta;
      logic     adv_x;
      logic     adv_y;
      logic     set_cell;
      logic     emit;
      cmd_type  cmd;
   } uword_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic no_req;
      logic ignore;
      logic big;
      logic x_done;
      logic y_done;
      logic out_free;
   } flags_type;

   // Strobes issued to the datapath for the current cycle
   typedef struct packed {
      logic    ld_in;
      logic    ld_clamp;
      logic    ld_delta;
      logic    adv_x;
      logic    adv_y;
      logic    set_cell;
      logic    emit;
      cmd_type cmd;
   } action_type;

   function automatic uword_type ucode_rom(step_type s);
      uword_type w;
      w = '{cond: C_NONE, jump: S_IDLE, next: S_IDLE, cmd: CMD_FINAL, default: 1'b0};
      case (s)
         S_IDLE: begin
            w.cond  = C_NO_REQ;
            w.jump  = S_IDLE;
            w.ld_in = 1'b1;
            w.next  = S_CLAMP;
         end
         S_CLAMP: begin
            w.cond     = C_IGNORE;
            w.jump     = S_IDLE;
            w.ld_clamp = 1'b1;
            w.next     = S_DELTA;
         end
         S_DELTA: begin
            w.ld_delta = 1'b1;
            w.next     = S_DECIDE;
         end
         S_DECIDE: begin
            w.cond = C_BIG;
            w.jump = S_REFILL;
            w.next = S_COL;
         end
         S_COL: begin
            w.cond  = C_X_DONE;
            w.jump  = S_ROW;
            w.adv_x = 1'b1;
            w.emit  = 1'b1;
            w.cmd   = CMD_COLUMN;
            w.next  = S_COL;
         end
         S_ROW: begin
            w.cond  = C_Y_DONE;
            w.jump  = S_FINAL;
            w.adv_y = 1'b1;
            w.emit  = 1'b1;
            w.cmd   = CMD_ROW;
            w.next  = S_ROW;
         end
         S_FINAL: begin
            w.emit = 1'b1;
            w.cmd  = CMD_FINAL;
            w.next = S_IDLE;
         end
         S_REFILL: begin
            w.emit     = 1'b1;
            w.set_cell = 1'b1;
            w.cmd      = CMD_REFILL;
            w.next     = S_IDLE;
         end
         default: begin
            w.next = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/tss_sequencer.sv =====
// Microcode sequencer for the tilemap scroll streamer: step counter, ROM
// lookup, condition test and stall on a busy output. Depends on tss_pkg.
`timescale 1ns / 1ps

module tss_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  tss_pkg::flags_type   flags,
   output tss_pkg::action_type act,
   output tss_pkg::step_type    step
);

   tss_pkg::step_type  step_ff, step_in;
   tss_pkg::uword_type uword;
   logic               cond_hit;
   logic               stall;

   assign uword = tss_pkg::ucode_rom(step_ff);
   assign step  = step_ff;

   always_comb begin
      case (uword.cond)
         tss_pkg::C_NONE:   cond_hit = 1'b0;
         tss_pkg::C_NO_REQ: cond_hit = flags.no_req;
         tss_pkg::C_IGNORE: cond_hit = flags.ignore;
         tss_pkg::C_BIG:    cond_hit = flags.big;
         tss_pkg::C_X_DONE: cond_hit = flags.x_done;
         tss_pkg::C_Y_DONE: cond_hit = flags.y_done;
         default:           cond_hit = 1'b0;
      endcase
   end

   // hold the step while an item waits for the output register
   assign stall = uword.emit && !flags.out_free;

   always_comb begin
      if (cond_hit) begin
         step_in = uword.jump;
      end else if (stall) begin
         step_in = step_ff;
      end else begin
         step_in = uword.next;
      end
   end

   always_comb begin
      act = '{cmd: tss_pkg::CMD_FINAL, default: 1'b0};
      if (!cond_hit && !stall) begin
         act.ld_in    = uword.ld_in;
         act.ld_clamp = uword.ld_clamp;
         act.ld_delta = uword.ld_delta;
         act.adv_x    = uword.adv_x;
         act.adv_y    = uword.adv_y;
         act.set_cell = uword.set_cell;
         act.emit     = uword.emit;
         act.cmd      = uword.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= tss_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/core/tilemap_scroll_streamer.sv =====
// Scroll streamer for one background plane: top level with APB registers,
// datapath and output register. Depends on tss_pkg and tss_sequencer.
`timescale 1ns / 1ps

// A scroll request is taken one at a time. After the beat is accepted the
// block clamps the target to the world, measures the distance to the stored
// ring origin and decides between incremental streaming and a refill, in the
// clamp, delta and decide steps. It then issues one command beat per cycle
// while the result channel does not stall, column updates first, then rows,
// then a closing beat with the scroll register values. Leaving the column
// loop and leaving the row loop each cost a step with no beat. A jump or an
// over-long move yields a single refill beat. A request with no map loaded,
// or for plane B in a mode without it, is dropped at the clamp step and
// yields no beat. A stalled result channel holds the sequencer at its
// current step. RING_COLS and RING_ROWS must be powers of two. The user
// must write registers only while no request is in flight; the block does
// not enforce this.

module tilemap_scroll_streamer #(
   parameter int RING_COLS       = 64,
   parameter int RING_ROWS       = 32,
   parameter int MAX_STREAM_CMDS = 63
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // target_x[15:0], target_y[31:16]
   input  logic        req_tuser,   // mode
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // world_cell[15:0], start_cell[31:16], ring_slot[37:32],
   // ring_base_addr[53:38], scroll_x_reg[62:54], scroll_y_reg[70:63], zero[71]
   output logic [71:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // command
   output logic        rsp_tlast,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic        map_loaded_ff;
   logic [2:0]  video_mode_ff;
   logic        plane_select_ff;
   logic [12:0] world_w_ff;
   logic [12:0] world_h_ff;
   logic [2:0]  csr_index;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_loaded_ff   <= 1'b0;
         video_mode_ff   <= 3'd0;
         plane_select_ff <= 1'b0;
         world_w_ff      <= 13'd0;
         world_h_ff      <= 13'd0;
      end else if (csr_write) begin
         case (csr_index)
            tss_pkg::REG_MAP_LOADED:   map_loaded_ff   <= csr_pwdata[0];
            tss_pkg::REG_VIDEO_MODE:   video_mode_ff   <= csr_pwdata[2:0];
            tss_pkg::REG_PLANE_SELECT: plane_select_ff <= csr_pwdata[0];
            tss_pkg::REG_WORLD_W:      world_w_ff      <= csr_pwdata[12:0];
            tss_pkg::REG_WORLD_H:      world_h_ff      <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tss_pkg::REG_MAP_LOADED:   csr_prdata = {31'd0, map_loaded_ff};
         tss_pkg::REG_VIDEO_MODE:   csr_prdata = {29'd0, video_mode_ff};
         tss_pkg::REG_PLANE_SELECT: csr_prdata = {31'd0, plane_select_ff};
         tss_pkg::REG_WORLD_W:      csr_prdata = {19'd0, world_w_ff};
         tss_pkg::REG_WORLD_H:      csr_prdata = {19'd0, world_h_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // Mode decode: plane B only in modes 0, 2 and 4; narrow screen in mode 4
   logic        has_b;
   logic [8:0]  screen_w;
   logic [15:0] ring_base;

   always_comb begin
      has_b    = video_mode_ff inside {3'd0, 3'd2, 3'd4};
      screen_w = (video_mode_ff == tss_pkg::VMODE_NARROW) ?
                 tss_pkg::SCREEN_W_NARROW : tss_pkg::SCREEN_W_STD;
      if (plane_select_ff) begin
         ring_base = tss_pkg::BASE_B_STD;
      end else if (video_mode_ff == tss_pkg::VMODE_HIGH_A ||
                   video_mode_ff == tss_pkg::VMODE_NARROW) begin
         ring_base = tss_pkg::BASE_A_HIGH;
      end else begin
         ring_base = tss_pkg::BASE_A_STD;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   tss_pkg::flags_type  flags;
   tss_pkg::action_type act;
   tss_pkg::step_type   step;

   tss_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .act   (act),
      .step  (step)
   );

   assign req_tready = (step == tss_pkg::S_IDLE);

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   logic        jump_ff;
   logic [15:0] tx_ff, ty_ff;
   logic [15:0] sx_ff, sy_ff, sx_in, sy_in;
   logic [16:0] adx_ff, ady_ff, adx_in, ady_in;
   logic [15:0] cell_x_ff, cell_y_ff, cell_x_in, cell_y_in;
   logic [12:0] nx, ny;

   // capture the request beat
   always_ff @(posedge clock) begin
      if (act.ld_in) begin
         jump_ff <= req_tuser;
         tx_ff   <= req_tdata[15:0];
         ty_ff   <= req_tdata[31:16];
      end
   end

   // clamp each axis to [0, world_px - screen], floor at zero
   logic signed [17:0] max_x, max_y;

   always_comb begin
      max_x = $signed({2'b00, world_w_ff, 3'b000}) - $signed(18'(screen_w));
      max_y = $signed({2'b00, world_h_ff, 3'b000}) - $signed(18'(tss_pkg::SCREEN_H));
      if (tx_ff[15] || max_x[17]) begin
         sx_in = 16'd0;
      end else if ({2'b00, tx_ff} > 18'(max_x)) begin
         sx_in = max_x[15:0];
      end else begin
         sx_in = tx_ff;
      end
      if (ty_ff[15] || max_y[17]) begin
         sy_in = 16'd0;
      end else if ({2'b00, ty_ff} > 18'(max_y)) begin
         sy_in = max_y[15:0];
      end else begin
         sy_in = ty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (act.ld_clamp) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
   end

   assign nx = sx_ff[15:3];
   assign ny = sy_ff[15:3];

   // distance in cells from the stored origin to the target
   logic [16:0] dx, dy;

   always_comb begin
      dx     = {1'b0, cell_x_ff} - {4'd0, nx};
      dy     = {1'b0, cell_y_ff} - {4'd0, ny};
      adx_in = dx[16] ? (17'd0 - dx) : dx;
      ady_in = dy[16] ? (17'd0 - dy) : dy;
   end

   always_ff @(posedge clock) begin
      if (act.ld_delta) begin
         adx_ff <= adx_in;
         ady_ff <= ady_in;
      end
   end

   // column and row step: move the origin one cell toward the target
   localparam logic [15:0] COL_MASK = 16'(RING_COLS - 1);
   localparam logic [15:0] ROW_MASK = 16'(RING_ROWS - 1);

   logic        x_up, y_up;
   logic [15:0] col_cell, row_cell;

   always_comb begin
      x_up      = cell_x_ff < {3'd0, nx};
      y_up      = cell_y_ff < {3'd0, ny};
      cell_x_in = x_up ? cell_x_ff + 16'd1 : cell_x_ff - 16'd1;
      cell_y_in = y_up ? cell_y_ff + 16'd1 : cell_y_ff - 16'd1;
      // leading edge of the ring when advancing, trailing edge when retreating
      col_cell  = x_up ? cell_x_ff + 16'(RING_COLS) : cell_x_in;
      row_cell  = y_up ? cell_y_ff + 16'(RING_ROWS) : cell_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_x_ff <= 16'd0;
         cell_y_ff <= 16'd0;
      end else if (act.set_cell) begin
         cell_x_ff <= {3'd0, nx};
         cell_y_ff <= {3'd0, ny};
      end else begin
         if (act.adv_x) begin
            cell_x_ff <= cell_x_in;
         end
         if (act.adv_y) begin
            cell_y_ff <= cell_y_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic        rsp_valid_ff;
   logic [1:0]  cmd_ff;
   logic        last_ff;
   logic [15:0] world_cell_ff, start_cell_ff, base_ff;
   logic [5:0]  slot_ff;
   logic [8:0]  sxr_ff;
   logic [7:0]  syr_ff;

   logic [15:0] world_cell_in, start_cell_in;
   logic [5:0]  slot_in;
   logic [8:0]  sxr_in;
   logic [7:0]  syr_in;
   logic        last_in;

   always_comb begin
      world_cell_in = 16'd0;
      start_cell_in = 16'd0;
      slot_in       = 6'd0;
      sxr_in        = 9'd0;
      syr_in        = 8'd0;
      last_in       = 1'b0;
      case (act.cmd)
         tss_pkg::CMD_COLUMN: begin
            world_cell_in = col_cell;
            start_cell_in = cell_y_ff;
            slot_in       = 6'(col_cell & COL_MASK);
         end
         tss_pkg::CMD_ROW: begin
            world_cell_in = row_cell;
            start_cell_in = cell_x_ff;
            slot_in       = 6'(row_cell & ROW_MASK);
         end
         tss_pkg::CMD_REFILL: begin
            world_cell_in = {3'd0, nx};
            start_cell_in = {3'd0, ny};
            sxr_in        = sx_ff[8:0];
            syr_in        = sy_ff[7:0];
            last_in       = 1'b1;
         end
         tss_pkg::CMD_FINAL: begin
            sxr_in  = sx_ff[8:0];
            syr_in  = sy_ff[7:0];
            last_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (act.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (act.emit) begin
         cmd_ff        <= act.cmd;
         world_cell_ff <= world_cell_in;
         start_cell_ff <= start_cell_in;
         slot_ff       <= slot_in;
         base_ff       <= ring_base;
         sxr_ff        <= sxr_in;
         syr_ff        <= syr_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = cmd_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {1'b0, syr_ff, sxr_ff, base_ff, slot_ff, start_cell_ff, world_cell_ff};

   // ------------------------------------------------------------------
   // Flags back to the sequencer
   // ------------------------------------------------------------------
   always_comb begin
      flags.no_req   = !req_tvalid;
      flags.ignore   = !map_loaded_ff || (plane_select_ff && !has_b);
      flags.big      = jump_ff ||
                       ({1'b0, adx_ff} + {1'b0, ady_ff} > 18'(MAX_STREAM_CMDS));
      flags.x_done   = (cell_x_ff == {3'd0, nx});
      flags.y_done   = (cell_y_ff == {3'd0, ny});
      flags.out_free = !rsp_valid_ff || rsp_tready;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // an accepted request always moves on to the clamp step
   a_accept_to_clamp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (step == tss_pkg::S_CLAMP))
      else $error("accepted request did not reach the clamp step");

   // the closing beat of a request carries either a refill or the final marker
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tuser == tss_pkg::CMD_FINAL || rsp_tuser == tss_pkg::CMD_REFILL))
      else $error("last beat with a streaming command");

   // a column beat moves the origin by exactly one cell
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      act.adv_x |=> (cell_x_ff == $past(cell_x_in)) && (cell_x_ff != $past(cell_x_ff)))
      else $error("column step did not move the origin");

   // a refill lands the origin on the target cell
   a_refill_origin: assert property (@(posedge clock) disable iff (reset)
      act.set_cell |=> (cell_x_ff == {3'd0, nx}) && (cell_y_ff == {3'd0, ny}))
      else $error("refill left the origin off target");

endmodule

// ===== sim/tilemap_scroll_streamer_tb.sv =====
// Self-checking testbench for the tilemap scroll streamer: directed and random scroll
// requests, an in-bench predictor of the ring-update command beats, random idling.
// Depends on tss_pkg and the tilemap_scroll_streamer RTL.
`timescale 1ns / 1ps

module tilemap_scroll_streamer_tb;
   import tss_pkg::*;

   localparam int RING_COLS       = 64;
   localparam int RING_ROWS       = 32;
   localparam int MAX_STREAM_CMDS = 63;
   localparam int WORLD_MAX       = 8191;

   // Video modes that carry a plane B, one bit per mode
   localparam logic [7:0] MODES_WITH_B = 8'b0001_0101;

   // Request mode carried on req_tuser
   localparam logic MODE_SMOOTH = 1'b0;
   localparam logic MODE_JUMP   = 1'b1;

   // One expected command beat, fields as they leave the block
   typedef struct {
      cmd_type     cmd;
      logic [15:0] world_cell;
      logic [15:0] start_cell;
      logic [5:0]  ring_slot;
      logic [15:0] ring_base;
      logic [8:0]  scroll_x_reg;
      logic [7:0]  scroll_y_reg;
      logic        last;
   } ring_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // target_x[15:0], target_y[31:16]
   logic        req_tuser = 1'b0;  // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // world_cell, start_cell, ring_slot, ring_base_addr, scroll_x_reg, scroll_y_reg, pad
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;         // command
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the register file
   logic        map_on = 1'b0;
   logic [2:0]  vmode = '0;
   logic        plane_b = 1'b0;
   logic [12:0] world_w = '0;
   logic [12:0] world_h = '0;

   // Shadow copy of the block state: ring origin and last clamped scroll
   logic [15:0] origin_x = '0;
   logic [15:0] origin_y = '0;
   int          scroll_x_now = 0;
   int          scroll_y_now = 0;

   ring_cmd_type pending_cmds[$];
   int          fail_count = 0;
   int          send_gap_pct = 0;
   int          stall_pct = 0;

   tilemap_scroll_streamer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Receiver: stall the result channel at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic int clamp_scroll(int target, int world_px, int screen);
      int limit;
      limit = world_px - screen;
      if (target < 0) return 0;
      if (limit < 0) limit = 0;
      return (target > limit) ? limit : target;
   endfunction

   function automatic void add_beat(cmd_type cmd, logic [15:0] wc, logic [15:0] sc,
                                    logic [5:0] slot, logic [15:0] base,
                                    logic [8:0] sxr, logic [7:0] syr, logic last);
      ring_cmd_type b;
      b.cmd          = cmd;
      b.world_cell   = wc;
      b.start_cell   = sc;
      b.ring_slot    = slot;
      b.ring_base    = base;
      b.scroll_x_reg = sxr;
      b.scroll_y_reg = syr;
      b.last         = last;
      pending_cmds.push_back(b);
   endfunction

   // Work out the command beats for one accepted request and advance the
   // shadow origin. Return the number of beats queued; 0 means ignored.
   function automatic int plan_scroll(logic jump, logic [15:0] tx, logic [15:0] ty);
      logic [15:0] nx, ny, wcell, base;
      int          sx, sy, adx, ady, screen_w, n;
      n = 0;
      // Ignore everything without a map, and plane B in modes lacking it
      if (!map_on || (plane_b && !MODES_WITH_B[vmode])) return 0;
      screen_w = (vmode == VMODE_NARROW) ? int'(SCREEN_W_NARROW) : int'(SCREEN_W_STD);
      sx = clamp_scroll(int'($signed(tx)), int'(world_w) * 8, screen_w);
      sy = clamp_scroll(int'($signed(ty)), int'(world_h) * 8, int'(SCREEN_H));
      nx = 16'(sx >> 3);
      ny = 16'(sy >> 3);
      if (plane_b) base = BASE_B_STD;
      else if (vmode == VMODE_HIGH_A || vmode == VMODE_NARROW) base = BASE_A_HIGH;
      else base = BASE_A_STD;
      scroll_x_now = sx;
      scroll_y_now = sy;
      adx = int'(nx) - int'(origin_x);
      ady = int'(ny) - int'(origin_y);
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;

      // Jump, or too far to stream: one refill beat, origin set directly
      if (jump || adx + ady > MAX_STREAM_CMDS) begin
         origin_x = nx;
         origin_y = ny;
         add_beat(CMD_REFILL, nx, ny, '0, base, 9'(sx), 8'(sy), 1'b1);
         return 1;
      end
      // Columns first, against the old row origin
      while (origin_x != nx) begin
         if (origin_x < nx) begin
            origin_x = origin_x + 16'd1;
            wcell    = origin_x + 16'(RING_COLS - 1);
         end else begin
            origin_x = origin_x - 16'd1;
            wcell    = origin_x;
         end
         add_beat(CMD_COLUMN, wcell, origin_y, 6'(wcell % RING_COLS), base, '0, '0, 1'b0);
         n++;
      end
      // Then rows, against the new column origin
      while (origin_y != ny) begin
         if (origin_y < ny) begin
            origin_y = origin_y + 16'd1;
            wcell    = origin_y + 16'(RING_ROWS - 1);
         end else begin
            origin_y = origin_y - 16'd1;
            wcell    = origin_y;
         end
         add_beat(CMD_ROW, wcell, origin_x, 6'(wcell % RING_ROWS), base, '0, '0, 1'b0);
         n++;
      end
      add_beat(CMD_FINAL, '0, '0, '0, base, 9'(sx), 8'(sy), 1'b1);
      return n + 1;
   endfunction

   // ------------------------------------------------------------------
   // Result checker: compare every accepted beat with the oldest expectation
   // ------------------------------------------------------------------

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      ring_cmd_type exp_beat;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            $display("%0t ns: unexpected beat, expected none, actual cmd %0h data %0h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            exp_beat = pending_cmds.pop_front();
            check_field("command",        16'(exp_beat.cmd),          16'(rsp_tuser));
            check_field("world_cell",     exp_beat.world_cell,        rsp_tdata[15:0]);
            check_field("start_cell",     exp_beat.start_cell,        rsp_tdata[31:16]);
            check_field("ring_slot",      16'(exp_beat.ring_slot),    16'(rsp_tdata[37:32]));
            check_field("ring_base_addr", exp_beat.ring_base,         rsp_tdata[53:38]);
            check_field("scroll_x_reg",   16'(exp_beat.scroll_x_reg), 16'(rsp_tdata[62:54]));
            check_field("scroll_y_reg",   16'(exp_beat.scroll_y_reg), 16'(rsp_tdata[70:63]));
            check_field("last",           16'(exp_beat.last),         16'(rsp_tlast));
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared stimulus tasks
   // ------------------------------------------------------------------

   // Offer one request beat, hold it until taken, then predict its results.
   // Valid is left high after the handshake so back-to-back beats need no drop.
   task automatic send_request(logic jump, logic [15:0] tx, logic [15:0] ty,
                               output int beats);
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ty, tx};
      req_tuser  <= jump;
      do @(posedge clock); while (!req_tready);
      beats = plan_scroll(jump, tx, ty);
   endtask

   // Drop valid and hold off until every expected beat has arrived, then give
   // an ignored request time to retire before anything touches the registers.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_cmds.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   // APB write: setup phase, then access phase, then the bus is released
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Program the whole register file and mirror it; call only when drained
   task automatic set_config(logic map, logic [2:0] vm, logic pl, logic [12:0] w,
                             logic [12:0] h);
      csr_write(REG_MAP_LOADED,   32'(map));
      csr_write(REG_VIDEO_MODE,   32'(vm));
      csr_write(REG_PLANE_SELECT, 32'(pl));
      csr_write(REG_WORLD_W,      32'(w));
      csr_write(REG_WORLD_H,      32'(h));
      map_on  = map;
      vmode   = vm;
      plane_b = pl;
      world_w = w;
      world_h = h;
   endtask

   function automatic logic [12:0] pick_world();
      case ($urandom_range(3))
         0:       return '0;
         1:       return 13'(WORLD_MAX);
         default: return 13'($urandom_range(600, 20));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Requests with no map, and for plane B where the mode has none, must
   // produce no beat and leave the origin alone.
   task automatic test_ignored_requests();
      int n;
      send_request(MODE_SMOOTH, 16'd100, 16'd100, n);
      send_request(MODE_JUMP, 16'hFFFF, 16'd5, n);
      wait_drain();
      set_config(1'b1, VMODE_HIGH_A, 1'b1, 13'(WORLD_MAX), 13'(WORLD_MAX));
      send_request(MODE_SMOOTH, 16'd64, 16'd64, n);
      wait_drain();
      set_config(1'b1, 3'd7, 1'b1, 13'(WORLD_MAX), 13'(WORLD_MAX));
      send_request(MODE_JUMP, 16'd640, 16'd640, n);
      wait_drain();
   endtask

   // Zero-step, a one-cell step on each axis, the longest stream, one step too many, jumps and
   // the extremes of the target range, on the largest world.
   task automatic test_streaming_limits();
      int n;
      set_config(1'b1, VMODE_NARROW, 1'b0, 13'(WORLD_MAX), 13'(WORLD_MAX));
      send_request(MODE_SMOOTH, 16'd0, 16'd0, n);
      send_request(MODE_SMOOTH, 16'd8, 16'd8, n);
      // Negative targets clamp to zero and step back down
      send_request(MODE_SMOOTH, 16'h8000, 16'h8000, n);
      // 62 columns plus 1 row: the longest run that still streams
      send_request(MODE_SMOOTH, 16'(62 * 8), 16'd8, n);
      // Sender holds off until the whole run has come back
      wait_drain();
      send_request(MODE_SMOOTH, 16'd0, 16'd0, n);
      // 64 steps: over the limit, so refill
      send_request(MODE_SMOOTH, 16'(64 * 8), 16'd0, n);
      send_request(MODE_SMOOTH, 16'h7FFF, 16'h7FFF, n);
      // Jump with no distance still refills
      send_request(MODE_JUMP, 16'h7FF8, 16'h7FFF, n);
      send_request(MODE_SMOOTH, 16'h7FFF - 16'd40, 16'h7FFF - 16'd17, n);
      wait_drain();
   endtask

   // Every video mode, plane A in even and plane B in odd ones, on a world just
   // over screen size so the clamp bites, then an empty world pinning scroll at zero.
   task automatic test_modes_and_clamp();
      int n;
      for (int m = 0; m < 8; m++) begin
         set_config(1'b1, 3'(m), 1'(m), 13'd41, 13'd30);
         send_request(MODE_SMOOTH, 16'd1000, 16'd1000, n);
         wait_drain();
      end
      set_config(1'b1, 3'd0, 1'b1, 13'd0, 13'd0);
      send_request(MODE_SMOOTH, 16'd3000, 16'hFFFB, n);
      wait_drain();
   endtask

   // Random traffic in four idling phases, a few register settings per phase.
   // Most requests are short smooth moves around the current scroll, so the
   // streaming paths get deep coverage; the rest are jumps and wild targets.
   task automatic test_random_traffic();
      int gap_tab[4]   = '{0, 47, 0, 30};
      int stall_tab[4] = '{0, 0, 47, 30};
      int n, counted, sent, pick;
      logic        jump;
      logic [15:0] tx, ty;
      for (int ph = 0; ph < 4; ph++) begin
         send_gap_pct = gap_tab[ph];
         stall_pct    = stall_tab[ph];
         for (int c = 0; c < 3; c++) begin
            set_config($urandom_range(9) != 0, 3'($urandom_range(7)),
                       $urandom_range(3) == 0, pick_world(), pick_world());
            counted = 0;
            sent    = 0;
            while (counted < 8 && sent < 12) begin
               pick = $urandom_range(99);
               if (pick < 65) begin
                  jump = MODE_SMOOTH;
                  tx   = 16'(scroll_x_now + int'($urandom_range(400)) - 200);
                  ty   = 16'(scroll_y_now + int'($urandom_range(240)) - 120);
               end else begin
                  jump = (pick < 80) ? MODE_JUMP : MODE_SMOOTH;
                  tx   = 16'($urandom);
                  ty   = 16'($urandom);
               end
               send_request(jump, tx, ty, n);
               sent++;
               if (n != 0) counted++;
               // Now and then let everything drain before the next beat
               if ($urandom_range(19) == 0) wait_drain();
            end
            wait_drain();
         end
      end
      send_gap_pct = 0;
      stall_pct    = 0;
   endtask

   // ------------------------------------------------------------------
   // Sequence and end of run
   // ------------------------------------------------------------------

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_ignored_requests();
      test_streaming_limits();
      test_modes_and_clamp();
      test_random_traffic();
      // Every beat is in; allow a full request's worth of cycles for strays
      wait_drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hard limit, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
